@@ hdl/khm_pkg.sv @@
// Shared constants, types and key helpers for the k-way heap merge block.
package khm_pkg;

  // Capacity of the heap: one entry per merged list
  localparam int LIST_COUNT_MAX = 16;
  // Lists that a 4-bit list index can name
  localparam int LIST_LIMIT     = (LIST_COUNT_MAX < 16) ? LIST_COUNT_MAX : 16;

  localparam int VALUE_W = 32;
  localparam int SRC_W   = 4;
  localparam int CFG_W   = 5;
  localparam int KEY_W   = VALUE_W + SRC_W;
  localparam int HEAP_AW = $clog2(LIST_COUNT_MAX);
  localparam int CNT_W   = $clog2(LIST_COUNT_MAX + 1);

  // Heap command from the merge control
  typedef struct packed {
    logic             start;
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] key;
  } heap_cmd_t;

  // Pop result offered by the heap unit
  typedef struct packed {
    logic             valid;
    logic             empty;
    logic [KEY_W-1:0] key;
  } heap_res_t;

  // Sort key: sign-flipped value, then source; unsigned compare gives the heap order
  function automatic logic [KEY_W-1:0] make_key(input logic signed [VALUE_W-1:0] value,
                                                input logic [SRC_W-1:0] src);
    make_key = {~value[VALUE_W-1], value[VALUE_W-2:0], src};
  endfunction

  function automatic logic signed [VALUE_W-1:0] key_value(input logic [KEY_W-1:0] key);
    key_value = {~key[KEY_W-1], key[KEY_W-2:SRC_W]};
  endfunction

  function automatic logic [SRC_W-1:0] key_src(input logic [KEY_W-1:0] key);
    key_src = key[SRC_W-1:0];
  endfunction

endpackage

@@ hdl/khm_heap.sv @@
// Min-heap unit: heap memory plus the push / pop / sift sequencer.
module khm_heap
  import khm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  heap_cmd_t cmd,
  output logic      idle,
  output heap_res_t res,
  input  logic      res_ready
);

  localparam int CW2 = HEAP_AW + 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PU_RD  = 7'b0000010,
    S_PU_CMP = 7'b0000100,
    S_PO_RD  = 7'b0001000,
    S_PO_EMIT= 7'b0010000,
    S_DN_RD  = 7'b0100000,
    S_DN_CMP = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [KEY_W-1:0]   cur, cur_next;
  logic [HEAP_AW-1:0] pos, pos_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop_pend, pop_pend_next;

  // Heap memory, two registered read ports and one write port
  logic [KEY_W-1:0]   mem [LIST_COUNT_MAX];
  logic [KEY_W-1:0]   rd_a, rd_b;
  logic [HEAP_AW-1:0] addr_a, addr_b, wr_addr;
  logic [KEY_W-1:0]   wr_data;
  logic               wr_en;

  // Tree navigation
  logic [HEAP_AW-1:0] parent;
  logic [CW2-1:0]     left_w, right_w, count_w;
  logic               left_ok, right_ok, take_right, child_less;
  logic [KEY_W-1:0]   child_key;
  logic [HEAP_AW-1:0] child_pos, last_pos;

  assign parent   = HEAP_AW'((pos - 1'b1) >> 1);
  assign left_w   = {1'b0, pos, 1'b1};
  assign right_w  = left_w + CW2'(1);
  assign count_w  = CW2'(count);
  assign left_ok  = left_w < count_w;
  assign right_ok = right_w < count_w;
  assign last_pos = HEAP_AW'(count - 1'b1);

  // Smaller child, then compare against the moving entry
  assign take_right = right_ok && (rd_b < rd_a);
  assign child_key  = take_right ? rd_b : rd_a;
  assign child_pos  = take_right ? HEAP_AW'(right_w) : HEAP_AW'(left_w);
  assign child_less = left_ok && (child_key < cur);

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    pos_next      = pos;
    count_next    = count;
    pop_pend_next = pop_pend;
    addr_a        = '0;
    addr_b        = '0;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = cur;
    res.valid     = 1'b0;
    res.empty     = (count == '0);
    res.key       = rd_a;
    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          pop_pend_next = cmd.pop;
          if (cmd.push && (count < CNT_W'(LIST_COUNT_MAX))) begin
            cur_next   = cmd.key;
            pos_next   = HEAP_AW'(count);
            count_next = count + 1'b1;
            state_next = S_PU_RD;
          end else if (cmd.pop) begin
            state_next = S_PO_RD;
          end
        end
      end
      S_PU_RD: begin
        addr_a = parent;
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = pop_pend ? S_PO_RD : S_IDLE;
        end else begin
          state_next = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        wr_en = 1'b1;
        if (cur < rd_a) begin
          wr_data    = rd_a;
          pos_next   = parent;
          state_next = S_PU_RD;
        end else begin
          state_next = pop_pend ? S_PO_RD : S_IDLE;
        end
      end
      S_PO_RD: begin
        addr_a     = '0;
        addr_b     = last_pos;
        state_next = S_PO_EMIT;
      end
      S_PO_EMIT: begin
        // Hold the same addresses so the read data stays put while stalled
        addr_a    = '0;
        addr_b    = last_pos;
        res.valid = 1'b1;
        if (res_ready) begin
          if (count == '0) begin
            state_next = S_IDLE;
          end else begin
            count_next = count - 1'b1;
            cur_next   = rd_b;
            pos_next   = '0;
            state_next = S_DN_RD;
          end
        end
      end
      S_DN_RD: begin
        addr_a     = HEAP_AW'(left_w);
        addr_b     = HEAP_AW'(right_w);
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (child_less) begin
          wr_data    = child_key;
          pos_next   = child_pos;
          state_next = S_DN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pop_pend <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      pop_pend <= pop_pend_next;
    end
    cur <= cur_next;
    pos <= pos_next;
  end

endmodule

@@ hdl/k_way_heap_merge.sv @@
// Top level of the k-way heap merge: phase control, config register, output register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_ready       | req_type, list_index, elem_value
//   output   | out_valid / out_ready     | out_value, source_list, has_value, done_res
//   config   | cfg_wr_en (no wait)       | cfg_wdata (num_lists)
//
// One transaction at a time: in_ready is high only while the heap sequencer idles.
// A push climbs one level per pass through S_PU_RD (read parent) and S_PU_CMP
// (compare and write); a pop reads root and last entry in S_PO_RD, offers the root
// in S_PO_EMIT, then sifts down one level per pass through S_DN_RD and S_DN_CMP.
// One item at a time is served, with the single heap memory and one compare path. Reset
// (rst, synchronous) empties the heap and returns to the fill phase; heap contents are
// not cleared. A stalled output only holds the sequencer once a new pop result is ready.
module k_way_heap_merge
  import khm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [SRC_W-1:0]          list_index,
  input  logic signed [VALUE_W-1:0] elem_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [SRC_W-1:0]          source_list,
  output logic                      has_value,
  output logic                      done_res
);

  logic [CFG_W-1:0] num_lists;
  logic [CFG_W-1:0] n_eff;
  logic [CFG_W-1:0] fill_count, fill_inc;
  logic             merging;
  logic [SRC_W-1:0] await_list;
  logic             in_take, item_match, fill_end;
  logic             res_ready, res_take;
  heap_cmd_t        cmd;
  heap_res_t        res;
  logic             heap_idle;

  // Effective list count: 0 acts as 1, saturate at the limit
  always_comb begin
    if (num_lists == '0) begin
      n_eff = CFG_W'(1);
    end else if (num_lists > CFG_W'(LIST_LIMIT)) begin
      n_eff = CFG_W'(LIST_LIMIT);
    end else begin
      n_eff = num_lists;
    end
  end

  assign in_ready = heap_idle;
  assign in_take  = in_valid && in_ready;
  assign fill_inc = fill_count + 1'b1;
  assign fill_end = fill_inc >= n_eff;

  // Item must name the list being filled or the list awaiting refill
  assign item_match = merging ? (list_index == await_list)
                              : (fill_count == {1'b0, list_index});

  assign cmd.start = in_take && item_match;
  assign cmd.push  = !req_type;
  assign cmd.pop   = merging || fill_end;
  assign cmd.key   = make_key(elem_value, list_index);

  khm_heap u_heap (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idle      (heap_idle),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid || out_ready;
  assign res_take  = res.valid && res_ready;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_lists <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      num_lists <= cfg_wdata;
    end
  end

  // Phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      merging    <= 1'b0;
      await_list <= '0;
    end else if (cmd.start && !merging) begin
      fill_count <= fill_inc;
      merging    <= fill_end;
    end else if (res_take) begin
      if (res.empty) begin
        merging    <= 1'b0;
        fill_count <= '0;
      end else begin
        await_list <= key_src(res.key);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_value   <= res.empty ? '0 : key_value(res.key);
      source_list <= res.empty ? '0 : key_src(res.key);
      has_value   <= !res.empty;
      done_res    <= res.empty;
    end
  end

endmodule
